// ----- rtl/plbt_pkg.sv -----
// Shared constants for the price level book best tracker.
package plbt_pkg;

  // Table geometry
  localparam int PRICE_LEVELS = 1024;
  localparam int LVL_W        = 10;
  localparam int QTY_W        = 32;
  localparam int BEST_W       = 11;

  localparam logic [LVL_W-1:0]  PRICE_MAX = LVL_W'(PRICE_LEVELS - 1);
  localparam logic [BEST_W-1:0] NO_PRICE  = '1;

  // Event kinds
  localparam logic [2:0] EV_SNAP_BEGIN  = 3'd0;
  localparam logic [2:0] EV_SNAP_LEVEL  = 3'd1;
  localparam logic [2:0] EV_SNAP_END    = 3'd2;
  localparam logic [2:0] EV_LEVEL_SET   = 3'd3;
  localparam logic [2:0] EV_LEVEL_CLEAR = 3'd4;

endpackage

// ----- rtl/plbt_level_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module plbt_level_ram #(
  parameter int DEPTH  = 1024,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/price_level_book_best_tracker_top.sv -----
// Top level of the price level book with best bid / best ask tracking.
//
// Input channel (in_*): one market event per transaction; the event kind and
// book side travel in in_tuser, price and quantity in in_tdata. Result
// channel (out_*): one result per event with the accepted flag in out_tuser
// and best bid, best ask and the quantity held at the event's price in
// out_tdata. Bests read -1 (all ones) when that side is empty.
// One event is in work at a time; in_tready is high only while idle.
// Writes that keep the best pass from the execute state straight to the result;
// snapshot end and unknown events add one RAM read, and removing the best
// level starts a rescan that walks the side's RAM read port one price level
// per cycle. Snapshot begin runs a clearing pass over both RAMs, then delivers
// its result. After reset the same clearing pass runs with in_tready low.
// A result waiting on a stalled receiver is held in the output register;
// the next event is accepted meanwhile and its work stops only when its own
// result is ready and the output register is still full.
module price_level_book_best_tracker_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // price_level[9:0], quantity[41:10], zero pad
  input  logic [3:0]  in_tuser,   // func[2:0], bid_side[3]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // best_bid[10:0], best_ask[21:11],
                                  // level_quantity[53:22], zero pad
  output logic        out_tuser   // accepted
);

  import plbt_pkg::*;

  // Sequencer states
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_RESP  = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [2:0]        func_r, func_nxt;
  logic              bid_r, bid_nxt;
  logic [LVL_W-1:0]  price_r, price_nxt;
  logic [QTY_W-1:0]  qty_r, qty_nxt;
  logic              acc_r, acc_nxt;
  logic [QTY_W-1:0]  held_r, held_nxt;
  logic [BEST_W-1:0] best_bid_r, best_bid_nxt;
  logic [BEST_W-1:0] best_ask_r, best_ask_nxt;
  logic [LVL_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic              clr_item_r, clr_item_nxt;
  logic [LVL_W-1:0]  scan_addr_r, scan_addr_nxt;
  logic              scan_more_r, scan_more_nxt;
  logic              chk_valid_r, chk_valid_nxt;
  logic [LVL_W-1:0]  chk_addr_r, chk_addr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_acc_r, out_acc_nxt;
  logic [BEST_W-1:0] out_bid_r, out_bid_nxt;
  logic [BEST_W-1:0] out_ask_r, out_ask_nxt;
  logic [QTY_W-1:0]  out_qty_r, out_qty_nxt;

  // RAM ports
  logic              bid_we, ask_we;
  logic [LVL_W-1:0]  ram_waddr, ram_raddr;
  logic [QTY_W-1:0]  ram_wdata;
  logic [QTY_W-1:0]  bid_rdata, ask_rdata, side_rdata;

  logic              in_fire, in_table, rd_nonzero;
  logic [QTY_W-1:0]  write_qty;
  logic [LVL_W-1:0]  scan_end;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign in_table   = ({1'b0, price_r} < BEST_W'(PRICE_LEVELS));
  assign write_qty  = (func_r == EV_LEVEL_CLEAR) ? '0 : qty_r;
  assign side_rdata = bid_r ? bid_rdata : ask_rdata;
  assign rd_nonzero = (side_rdata != '0);
  assign scan_end   = bid_r ? '0 : PRICE_MAX;
  assign ram_raddr  = (state_r == ST_SCAN) ? scan_addr_r : price_r;

  plbt_level_ram #(.DEPTH(PRICE_LEVELS), .WIDTH(QTY_W), .ADDR_W(LVL_W)) u_bid_ram (
    .clk   (clk),
    .we    (bid_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (bid_rdata)
  );

  plbt_level_ram #(.DEPTH(PRICE_LEVELS), .WIDTH(QTY_W), .ADDR_W(LVL_W)) u_ask_ram (
    .clk   (clk),
    .we    (ask_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ask_rdata)
  );

  // Sequencer and datapath next state
  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    bid_nxt       = bid_r;
    price_nxt     = price_r;
    qty_nxt       = qty_r;
    acc_nxt       = acc_r;
    held_nxt      = held_r;
    best_bid_nxt  = best_bid_r;
    best_ask_nxt  = best_ask_r;
    clr_addr_nxt  = clr_addr_r;
    clr_item_nxt  = clr_item_r;
    scan_addr_nxt = scan_addr_r;
    scan_more_nxt = scan_more_r;
    chk_valid_nxt = chk_valid_r;
    chk_addr_nxt  = chk_addr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_acc_nxt   = out_acc_r;
    out_bid_nxt   = out_bid_r;
    out_ask_nxt   = out_ask_r;
    out_qty_nxt   = out_qty_r;
    bid_we        = 1'b0;
    ask_we        = 1'b0;
    ram_waddr     = price_r;
    ram_wdata     = write_qty;

    unique case (state_r)
      ST_CLEAR: begin
        // Zero one level of both tables per cycle
        bid_we       = 1'b1;
        ask_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == PRICE_MAX) begin
          state_nxt = clr_item_r ? ST_RESP : ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_fire) begin
          func_nxt  = in_tuser[2:0];
          bid_nxt   = in_tuser[3];
          price_nxt = in_tdata[9:0];
          qty_nxt   = in_tdata[41:10];
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        unique case (func_r) inside
          EV_SNAP_BEGIN: begin
            acc_nxt      = 1'b1;
            held_nxt     = '0;
            best_bid_nxt = NO_PRICE;
            best_ask_nxt = NO_PRICE;
            clr_addr_nxt = '0;
            clr_item_nxt = 1'b1;
            state_nxt    = ST_CLEAR;
          end
          EV_SNAP_LEVEL, EV_LEVEL_SET, EV_LEVEL_CLEAR: begin
            state_nxt = ST_RESP;
            if (in_table) begin
              acc_nxt  = 1'b1;
              held_nxt = write_qty;
              bid_we   = bid_r;
              ask_we   = !bid_r;
              if (bid_r) begin
                if (write_qty != '0) begin
                  if (best_bid_r[BEST_W-1] || (price_r > best_bid_r[LVL_W-1:0])) begin
                    best_bid_nxt = {1'b0, price_r};
                  end
                end else if (best_bid_r == {1'b0, price_r}) begin
                  // Best level removed: walk down from the next lower price
                  if (price_r == '0) begin
                    best_bid_nxt = NO_PRICE;
                  end else begin
                    scan_addr_nxt = price_r - 1'b1;
                    scan_more_nxt = 1'b1;
                    chk_valid_nxt = 1'b0;
                    state_nxt     = ST_SCAN;
                  end
                end
              end else begin
                if (write_qty != '0) begin
                  if (best_ask_r[BEST_W-1] || (price_r < best_ask_r[LVL_W-1:0])) begin
                    best_ask_nxt = {1'b0, price_r};
                  end
                end else if (best_ask_r == {1'b0, price_r}) begin
                  // Best level removed: walk up from the next higher price
                  if (price_r == PRICE_MAX) begin
                    best_ask_nxt = NO_PRICE;
                  end else begin
                    scan_addr_nxt = price_r + 1'b1;
                    scan_more_nxt = 1'b1;
                    chk_valid_nxt = 1'b0;
                    state_nxt     = ST_SCAN;
                  end
                end
              end
            end else begin
              acc_nxt  = 1'b0;
              held_nxt = '0;
            end
          end
          default: begin
            // Snapshot end is accepted, unknown kinds are not; both report
            acc_nxt = (func_r == EV_SNAP_END);
            if (in_table) begin
              state_nxt = ST_READ;
            end else begin
              held_nxt  = '0;
              state_nxt = ST_RESP;
            end
          end
        endcase
      end

      ST_READ: begin
        held_nxt  = side_rdata;
        state_nxt = ST_RESP;
      end

      ST_SCAN: begin
        // Pipelined walk: issue one address, check the one before it
        if (chk_valid_r && rd_nonzero) begin
          if (bid_r) begin
            best_bid_nxt = {1'b0, chk_addr_r};
          end else begin
            best_ask_nxt = {1'b0, chk_addr_r};
          end
          state_nxt = ST_RESP;
        end else if (chk_valid_r && (chk_addr_r == scan_end)) begin
          if (bid_r) begin
            best_bid_nxt = NO_PRICE;
          end else begin
            best_ask_nxt = NO_PRICE;
          end
          state_nxt = ST_RESP;
        end else begin
          chk_valid_nxt = scan_more_r;
          chk_addr_nxt  = scan_addr_r;
          if (scan_addr_r == scan_end) begin
            scan_more_nxt = 1'b0;
          end else if (bid_r) begin
            scan_addr_nxt = scan_addr_r - 1'b1;
          end else begin
            scan_addr_nxt = scan_addr_r + 1'b1;
          end
        end
      end

      ST_RESP: begin
        // Load the output register once it is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_acc_nxt   = acc_r;
          out_bid_nxt   = best_bid_r;
          out_ask_nxt   = best_ask_r;
          out_qty_nxt   = held_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      clr_item_r   <= 1'b0;
      best_bid_r   <= NO_PRICE;
      best_ask_r   <= NO_PRICE;
      out_valid_r  <= 1'b0;
      chk_valid_r  <= 1'b0;
      scan_more_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      clr_item_r   <= clr_item_nxt;
      best_bid_r   <= best_bid_nxt;
      best_ask_r   <= best_ask_nxt;
      out_valid_r  <= out_valid_nxt;
      chk_valid_r  <= chk_valid_nxt;
      scan_more_r  <= scan_more_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    bid_r       <= bid_nxt;
    price_r     <= price_nxt;
    qty_r       <= qty_nxt;
    acc_r       <= acc_nxt;
    held_r      <= held_nxt;
    scan_addr_r <= scan_addr_nxt;
    chk_addr_r  <= chk_addr_nxt;
    out_acc_r   <= out_acc_nxt;
    out_bid_r   <= out_bid_nxt;
    out_ask_r   <= out_ask_nxt;
    out_qty_r   <= out_qty_nxt;
  end

  // Result channel
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_acc_r;
  assign out_tdata  = {2'b00, out_qty_r, out_ask_r, out_bid_r};

  // A negative best is only ever the empty marker
  a_bid_empty_code: assert property (@(posedge clk) disable iff (!rst_n)
    best_bid_r[BEST_W-1] |-> (best_bid_r == NO_PRICE))
    else $error("best bid holds a negative value other than empty");

  a_ask_empty_code: assert property (@(posedge clk) disable iff (!rst_n)
    best_ask_r[BEST_W-1] |-> (best_ask_r == NO_PRICE))
    else $error("best ask holds a negative value other than empty");

  // One event in work at a time
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("input accepted while an event is still in work");

  // The bid rescan issues addresses below the one it checks, so it walks downward
  a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCAN) && chk_valid_r && scan_more_r && bid_r) |->
      (scan_addr_r < chk_addr_r))
    else $error("bid rescan is not walking downward");

endmodule
